>>> design/v3alu_pkg.sv
// Shared types, operation codes and saturation helpers for the vector ALU.
// Used by every module of the block; depends on nothing else.
package v3alu_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int EXT_W  = 2 * DATA_W + 2;

    typedef logic [2:0] op_t;

    localparam op_t OP_ADD   = 3'd0;
    localparam op_t OP_SUB   = 3'd1;
    localparam op_t OP_SCALE = 3'd2;
    localparam op_t OP_DOT   = 3'd3;
    localparam op_t OP_CROSS = 3'd4;
    localparam op_t OP_LEN   = 3'd5;
    localparam op_t OP_NORM  = 3'd6;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] ax;
        logic signed [DATA_W-1:0] ay;
        logic signed [DATA_W-1:0] az;
        logic signed [DATA_W-1:0] bx;
        logic signed [DATA_W-1:0] by;
        logic signed [DATA_W-1:0] bz;
        logic signed [DATA_W-1:0] factor;
    } vec_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] rx;
        logic signed [DATA_W-1:0] ry;
        logic signed [DATA_W-1:0] rz;
        logic signed [DATA_W-1:0] scalar;
        logic                     overflow;
        logic                     zero_length;
    } vec_res_t;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] value;
    } sat_t;

    localparam logic signed [EXT_W-1:0] SAT_MAX =
        {{(EXT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_MIN =
        {{(EXT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // Clamp a wide signed value into the data range and flag when it was clamped.
    function automatic sat_t sat_ext(input logic signed [EXT_W-1:0] v);
        sat_t s;
        if (v > SAT_MAX) begin
            s.ovf   = 1'b1;
            s.value = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            s.ovf   = 1'b1;
            s.value = SAT_MIN[DATA_W-1:0];
        end else begin
            s.ovf   = 1'b0;
            s.value = v[DATA_W-1:0];
        end
        return s;
    endfunction

    function automatic logic signed [EXT_W-1:0] sext_d(input logic signed [DATA_W-1:0] x);
        return $signed({{(EXT_W-DATA_W){x[DATA_W-1]}}, x});
    endfunction

    function automatic logic signed [EXT_W-1:0] sext_p(input logic signed [PROD_W-1:0] x);
        return $signed({{(EXT_W-PROD_W){x[PROD_W-1]}}, x});
    endfunction

    function automatic logic signed [EXT_W-1:0] zext_d(input logic [DATA_W-1:0] x);
        return $signed({{(EXT_W-DATA_W){1'b0}}, x});
    endfunction

endpackage

>>> design/v3alu_lane.sv
// One component lane of the vector ALU: two multipliers, then the per-component result.
// Depends on v3alu_pkg.
module v3alu_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  v3alu_pkg::op_t                         op,
    input  logic signed [v3alu_pkg::DATA_W-1:0]    a_self,
    input  logic signed [v3alu_pkg::DATA_W-1:0]    a_next,
    input  logic signed [v3alu_pkg::DATA_W-1:0]    a_prev,
    input  logic signed [v3alu_pkg::DATA_W-1:0]    b_self,
    input  logic signed [v3alu_pkg::DATA_W-1:0]    b_next,
    input  logic signed [v3alu_pkg::DATA_W-1:0]    b_prev,
    input  logic signed [v3alu_pkg::DATA_W-1:0]    factor,
    output logic signed [v3alu_pkg::PROD_W-1:0]    prod,
    output logic signed [v3alu_pkg::DATA_W-1:0]    comp,
    output logic                                   ovf
);
    import v3alu_pkg::*;

    logic signed [DATA_W-1:0] m1x;
    logic signed [DATA_W-1:0] m1y;
    op_t                      op_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [EXT_W-1:0]  sum_ab;
    logic signed [EXT_W-1:0]  dif_ab;
    logic signed [EXT_W-1:0]  scl;
    logic signed [EXT_W-1:0]  crs;
    sat_t                     s_next;
    sat_t                     s_reg;

    // The first multiplier is shared by scale, dot, cross and the squares.
    always_comb
    begin
        m1x = a_self;
        m1y = b_self;
        case (op)
            OP_SCALE:
            begin
                m1x = factor;
                m1y = a_self;
            end
            OP_CROSS:
            begin
                m1x = a_next;
                m1y = b_prev;
            end
            OP_LEN, OP_NORM:
            begin
                m1y = a_self;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg <= op;
            a_reg  <= a_self;
            b_reg  <= b_self;
            p1_reg <= PROD_W'(m1x) * PROD_W'(m1y);
            p2_reg <= PROD_W'(a_prev) * PROD_W'(b_next);
        end
    end

    always_comb
    begin
        sum_ab = sext_d(a_reg) + sext_d(b_reg);
        dif_ab = sext_d(a_reg) - sext_d(b_reg);
        scl    = sext_p(p1_reg) >>> FRAC_BITS;
        crs    = (sext_p(p1_reg) - sext_p(p2_reg)) >>> FRAC_BITS;
        case (op_reg)
            OP_ADD:   s_next = sat_ext(sum_ab);
            OP_SUB:   s_next = sat_ext(dif_ab);
            OP_SCALE: s_next = sat_ext(scl);
            OP_CROSS: s_next = sat_ext(crs);
            default:  s_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
        end
    end

    assign prod = p1_reg;
    assign comp = $signed(s_reg.value);
    assign ovf  = s_reg.ovf;

endmodule

>>> design/v3alu_sqrt.sv
// Pipelined integer square root, one result bit per stage, rounding down.
// Depends on v3alu_pkg.
module v3alu_sqrt (
    input  logic                              clk,
    input  logic                              en,
    input  logic [v3alu_pkg::PROD_W-1:0]      rad,
    output logic [v3alu_pkg::DATA_W-1:0]      root
);
    import v3alu_pkg::*;

    localparam int RW = DATA_W + 3;

    logic [RW-1:0]     rem_reg  [1:DATA_W];
    logic [DATA_W-1:0] root_reg [1:DATA_W];
    logic [PROD_W-1:0] rad_reg  [1:DATA_W];
    logic [RW-1:0]     rem_prev  [0:DATA_W-1];
    logic [DATA_W-1:0] root_prev [0:DATA_W-1];
    logic [PROD_W-1:0] rad_prev  [0:DATA_W-1];

    for (genvar k = 0; k < DATA_W; k++)
    begin : g_step
        logic [RW-1:0] nr;
        logic [RW-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_prev[k]  = '0;
            assign root_prev[k] = '0;
            assign rad_prev[k]  = rad;
        end else begin : g_rest
            assign rem_prev[k]  = rem_reg[k];
            assign root_prev[k] = root_reg[k];
            assign rad_prev[k]  = rad_reg[k];
        end

        assign nr    = {rem_prev[k][RW-3:0], rad_prev[k][PROD_W-1 -: 2]};
        assign trial = {1'b0, root_prev[k], 2'b01};
        assign ge    = (nr >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? (nr - trial) : nr;
                root_reg[k+1] <= {root_prev[k][DATA_W-2:0], ge};
                rad_reg[k+1]  <= {rad_prev[k][PROD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[DATA_W];

endmodule

>>> design/v3alu_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on v3alu_pkg.
module v3alu_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic [v3alu_pkg::DATA_W+FRAC_BITS-1:0]     num,
    input  logic [v3alu_pkg::DATA_W-1:0]               den,
    output logic [v3alu_pkg::DATA_W+FRAC_BITS-1:0]     quo
);
    import v3alu_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;

    logic [DATA_W-1:0] rem_reg [1:NW];
    logic [NW-1:0]     quo_reg [1:NW];
    logic [NW-1:0]     num_reg [1:NW];
    logic [DATA_W-1:0] den_reg [1:NW];
    logic [DATA_W-1:0] rem_prev [0:NW-1];
    logic [NW-1:0]     quo_prev [0:NW-1];
    logic [NW-1:0]     num_prev [0:NW-1];
    logic [DATA_W-1:0] den_prev [0:NW-1];

    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic [DATA_W:0] nr;
        logic [DATA_W:0] diff;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rem_prev[k] = '0;
            assign quo_prev[k] = '0;
            assign num_prev[k] = num;
            assign den_prev[k] = den;
        end else begin : g_rest
            assign rem_prev[k] = rem_reg[k];
            assign quo_prev[k] = quo_reg[k];
            assign num_prev[k] = num_reg[k];
            assign den_prev[k] = den_reg[k];
        end

        assign nr   = {rem_prev[k], num_prev[k][NW-1]};
        assign ge   = (nr >= {1'b0, den_prev[k]});
        assign diff = nr - {1'b0, den_prev[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[DATA_W-1:0] : nr[DATA_W-1:0];
                quo_reg[k+1] <= {quo_prev[k][NW-2:0], ge};
                num_reg[k+1] <= {num_prev[k][NW-2:0], 1'b0};
                den_reg[k+1] <= den_prev[k];
            end
        end
    end

    assign quo = quo_reg[NW];

endmodule

>>> design/vec3_fixed_point_alu.sv
// Three-component signed fixed-point vector ALU, top level.
// Depends on v3alu_pkg, v3alu_lane, v3alu_sqrt and v3alu_div.

// The unit takes one command word per clock while not stalled and returns exactly
// one result word per command, in order. Every operation travels down the same
// pipeline: an input register, three component lanes with their multipliers, a
// merge stage for the dot product and the sum of squares, a square root that
// resolves one bit per stage (32 stages), three dividers for normalize that
// resolve one quotient bit per stage (32 + FRAC_BITS stages), and the output
// register. The whole pipeline advances together; it holds only while a
// result word sits in the output register and the consumer stalls it, so a
// stall on the result side reaches the command side in the same cycle.
// Values outside the signed range saturate and set overflow. Normalizing a zero
// vector returns all zeros with zero_length set.
module vec3_fixed_point_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  v3alu_pkg::vec_cmd_t   cmd,
    output logic                  res_valid,
    input  logic                  res_stall,
    output v3alu_pkg::vec_res_t   res
);
    import v3alu_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int DEPTH = 3 + DATA_W + NUM_W;

    typedef struct packed {
        op_t                    op;
        logic [2:0][DATA_W-1:0] r;
        logic [DATA_W-1:0]      sc;
        logic                   ovf;
        logic [2:0][DATA_W-1:0] mag;
        logic [2:0]             neg;
    } side1_t;

    typedef struct packed {
        op_t                    op;
        logic [2:0][DATA_W-1:0] r;
        logic [DATA_W-1:0]      sc;
        logic                   ovf;
        logic [DATA_W-1:0]      root;
        logic [2:0]             neg;
    } side2_t;

    logic                     adv;
    logic [DEPTH-1:0]         vld_reg;
    logic                     res_vld_reg;
    vec_res_t                 res_reg;
    vec_res_t                 res_next;

    op_t                      op1_reg;
    logic signed [DATA_W-1:0] a1_reg [3];
    logic signed [DATA_W-1:0] b1_reg [3];
    logic signed [DATA_W-1:0] f1_reg;

    op_t                      op2_reg;
    logic signed [DATA_W-1:0] a2_reg [3];

    logic signed [PROD_W-1:0] prod [3];
    logic signed [DATA_W-1:0] comp [3];
    logic [2:0]               lovf;

    logic signed [EXT_W-1:0]  dot_sum;
    sat_t                     dot_sat;
    op_t                      op3_reg;
    logic [DATA_W-1:0]        sc3_reg;
    logic                     dovf3_reg;
    logic [PROD_W-1:0]        sumsq3_reg;
    logic [DATA_W-1:0]        mag3_reg [3];
    logic [2:0]               neg3_reg;

    side1_t                   side1_in;
    side1_t                   side1_reg [1:DATA_W];
    logic [DATA_W-1:0]        root;
    side2_t                   side2_in;
    side2_t                   side2_reg [1:NUM_W];
    logic [NUM_W-1:0]         quo [3];

    side2_t                   fin;
    sat_t                     len_sat;
    sat_t                     q_sat [3];

    // The pipeline moves whenever the output register is free or being drained.
    assign adv       = !res_vld_reg || !res_stall;
    assign cmd_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end else if (adv)
        begin
            vld_reg     <= {vld_reg[DEPTH-2:0], cmd_valid};
            res_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg   <= cmd.op;
            a1_reg[0] <= cmd.ax;
            a1_reg[1] <= cmd.ay;
            a1_reg[2] <= cmd.az;
            b1_reg[0] <= cmd.bx;
            b1_reg[1] <= cmd.by;
            b1_reg[2] <= cmd.bz;
            f1_reg    <= cmd.factor;
        end
    end

    // Component lanes. Lane i forms its own cross-product term from the other two axes.
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        v3alu_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (adv),
            .op     (op1_reg),
            .a_self (a1_reg[i]),
            .a_next (a1_reg[(i+1)%3]),
            .a_prev (a1_reg[(i+2)%3]),
            .b_self (b1_reg[i]),
            .b_next (b1_reg[(i+1)%3]),
            .b_prev (b1_reg[(i+2)%3]),
            .factor (f1_reg),
            .prod   (prod[i]),
            .comp   (comp[i]),
            .ovf    (lovf[i])
        );
    end

    // Keep the operation and vector a in step with the lanes' product stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg <= op1_reg;
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i] <= a1_reg[i];
            end
        end
    end

    // Merge stage: the three lane products summed exactly. For dot this is the
    // dot product before the shift; for length and normalize the sum of squares.
    assign dot_sum = sext_p(prod[0]) + sext_p(prod[1]) + sext_p(prod[2]);
    assign dot_sat = sat_ext(dot_sum >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op3_reg    <= op2_reg;
            sumsq3_reg <= dot_sum[PROD_W-1:0];
            if (op2_reg == OP_DOT)
            begin
                sc3_reg   <= dot_sat.value;
                dovf3_reg <= dot_sat.ovf;
            end else begin
                sc3_reg   <= '0;
                dovf3_reg <= 1'b0;
            end
            for (int i = 0; i < 3; i++)
            begin
                neg3_reg[i] <= a2_reg[i][DATA_W-1];
                mag3_reg[i] <= a2_reg[i][DATA_W-1] ? DATA_W'(-a2_reg[i]) : a2_reg[i];
            end
        end
    end

    always_comb
    begin
        side1_in.op  = op3_reg;
        side1_in.sc  = sc3_reg;
        side1_in.ovf = dovf3_reg | (|lovf);
        side1_in.neg = neg3_reg;
        for (int i = 0; i < 3; i++)
        begin
            side1_in.r[i]   = comp[i];
            side1_in.mag[i] = mag3_reg[i];
        end
    end

    // Square root of the sum of squares; the finished results ride alongside.
    v3alu_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (sumsq3_reg),
        .root (root)
    );

    for (genvar k = 1; k <= DATA_W; k++)
    begin : g_side1
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (k == 1)
                begin
                    side1_reg[k] <= side1_in;
                end else begin
                    side1_reg[k] <= side1_reg[k-1];
                end
            end
        end
    end

    // Normalize: |a_i| scaled up by the fraction width and divided by the length.
    for (genvar i = 0; i < 3; i++)
    begin : g_div
        v3alu_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num ({side1_reg[DATA_W].mag[i], {FRAC_BITS{1'b0}}}),
            .den (root),
            .quo (quo[i])
        );
    end

    always_comb
    begin
        side2_in.op   = side1_reg[DATA_W].op;
        side2_in.r    = side1_reg[DATA_W].r;
        side2_in.sc   = side1_reg[DATA_W].sc;
        side2_in.ovf  = side1_reg[DATA_W].ovf;
        side2_in.neg  = side1_reg[DATA_W].neg;
        side2_in.root = root;
    end

    for (genvar k = 1; k <= NUM_W; k++)
    begin : g_side2
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (k == 1)
                begin
                    side2_reg[k] <= side2_in;
                end else begin
                    side2_reg[k] <= side2_reg[k-1];
                end
            end
        end
    end

    // Final selection into the output register.
    assign fin     = side2_reg[NUM_W];
    assign len_sat = sat_ext(zext_d(fin.root));

    for (genvar i = 0; i < 3; i++)
    begin : g_qsat
        logic signed [EXT_W-1:0] q_ext;
        assign q_ext    = $signed({{(EXT_W-NUM_W){1'b0}}, quo[i]});
        assign q_sat[i] = sat_ext(fin.neg[i] ? -q_ext : q_ext);
    end

    always_comb
    begin
        res_next = '0;
        case (fin.op)
            OP_ADD, OP_SUB, OP_SCALE, OP_DOT, OP_CROSS:
            begin
                res_next.rx       = $signed(fin.r[0]);
                res_next.ry       = $signed(fin.r[1]);
                res_next.rz       = $signed(fin.r[2]);
                res_next.scalar   = $signed(fin.sc);
                res_next.overflow = fin.ovf;
            end
            OP_LEN:
            begin
                res_next.scalar   = $signed(len_sat.value);
                res_next.overflow = len_sat.ovf;
            end
            OP_NORM:
            begin
                if (fin.root == '0)
                begin
                    res_next.zero_length = 1'b1;
                end else begin
                    res_next.rx       = $signed(q_sat[0].value);
                    res_next.ry       = $signed(q_sat[1].value);
                    res_next.rz       = $signed(q_sat[2].value);
                    res_next.scalar   = $signed(len_sat.value);
                    res_next.overflow = len_sat.ovf | q_sat[0].ovf | q_sat[1].ovf
                                        | q_sat[2].ovf;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    // A zero-length normalize must come out fully cleared.
    a_zero_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.zero_length |-> !res.overflow && res.rx == '0 && res.ry == '0
            && res.rz == '0 && res.scalar == '0)
        else $error("zero_length result carries nonzero fields");

    // Only a dot product may leave a scalar in the merge stage.
    a_merge_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && op3_reg != OP_DOT |-> sc3_reg == '0 && !dovf3_reg)
        else $error("merge stage produced a scalar for a non-dot operation");

    // A word accepted at the input shows up in the first pipeline stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> vld_reg[0])
        else $error("accepted command word was not captured");

endmodule
